/* src/chisq_pkg.sv */
// Shared types and constants of the two-row chi-square statistic core.
`timescale 1ns / 1ps
package chisq_pkg;

   localparam int DEF_MAX_COLUMNS   = 16;
   localparam int DEF_COUNT_BITS    = 20;
   localparam int DEF_FRACTION_BITS = 16;
   localparam int VALUE_BITS        = 48;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CHECK,
      ST_READ,
      ST_TCHK,
      ST_MUL_A,
      ST_MUL_B,
      ST_SQ,
      ST_MUL_D,
      ST_MUL_DEN,
      ST_DIV,
      ST_NEXT,
      ST_FINISH
   } state_type;

   // Operand pairs of the shared serial multiplier.
   typedef enum logic [1:0] {
      MSEL_N_O0,
      MSEL_T_R0,
      MSEL_D_D,
      MSEL_B_R1
   } mul_sel_type;

   typedef struct packed {
      logic        accept_col;
      logic        check;
      logic        col_clear;
      logic        col_inc;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        cap_a;
      logic        cap_b;
      logic        num_load;
      logic        div_start;
      logic        acc;
      logic        out_write;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic row_zero;
      logic t_zero;
      logic mul_busy;
      logic div_busy;
      logic col_last;
      logic rsp_busy;
   } status_type;

endpackage

/* src/chisq_ctrl.sv */
// Controller state machine that sequences loading and the closing pass.
`timescale 1ns / 1ps
module chisq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   input  chisq_pkg::status_type  status,
   output logic                   req_tready,
   output chisq_pkg::cmd_type     cmd
);
   import chisq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tlast) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.n_zero || status.row_zero) state_in = ST_FINISH;
            else state_in = ST_READ;
         end
         ST_READ: state_in = ST_TCHK;
         ST_TCHK: begin
            if (status.t_zero) state_in = ST_NEXT;
            else state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            if (!status.mul_busy) state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            if (!status.mul_busy) state_in = ST_SQ;
         end
         ST_SQ: state_in = ST_MUL_D;
         ST_MUL_D: begin
            if (!status.mul_busy) state_in = ST_MUL_DEN;
         end
         ST_MUL_DEN: begin
            if (!status.mul_busy) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (status.col_last) state_in = ST_FINISH;
            else state_in = ST_READ;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready     = 1'b1;
            cmd.accept_col = req_tvalid;
         end
         ST_CHECK: begin
            cmd.check     = 1'b1;
            cmd.col_clear = 1'b1;
         end
         ST_READ: ;
         ST_TCHK: begin
            if (!status.t_zero) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_N_O0;
            end
         end
         ST_MUL_A: begin
            if (!status.mul_busy) begin
               cmd.cap_a     = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_T_R0;
            end
         end
         ST_MUL_B: begin
            if (!status.mul_busy) cmd.cap_b = 1'b1;
         end
         ST_SQ: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_D_D;
         end
         ST_MUL_D: begin
            if (!status.mul_busy) begin
               cmd.num_load  = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_B_R1;
            end
         end
         ST_MUL_DEN: begin
            if (!status.mul_busy) cmd.div_start = 1'b1;
         end
         ST_DIV: begin
            if (!status.div_busy) cmd.acc = 1'b1;
         end
         ST_NEXT: begin
            if (!status.col_last) cmd.col_inc = 1'b1;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) cmd.out_write = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

/* src/chisq_dp.sv */
// Datapath: column stores, row totals, serial multiplier, serial divider, result register.
`timescale 1ns / 1ps
module chisq_dp #(
   parameter int MAX_COLUMNS   = chisq_pkg::DEF_MAX_COLUMNS,
   parameter int COUNT_BITS    = chisq_pkg::DEF_COUNT_BITS,
   parameter int FRACTION_BITS = chisq_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  chisq_pkg::cmd_type                  cmd,
   input  logic [COUNT_BITS-1:0]               unaffected_count,
   input  logic [COUNT_BITS-1:0]               affected_count,
   input  logic                                rsp_tready,
   output chisq_pkg::status_type               status,
   output logic                                rsp_tvalid,
   output logic [chisq_pkg::VALUE_BITS-1:0]    chi_square_value,
   output logic                                row_total_zero,
   output logic                                column_overflow
);
   import chisq_pkg::*;

   localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int LW   = $clog2(MAX_COLUMNS + 1);
   localparam int TOTW = COUNT_BITS + $clog2(MAX_COLUMNS);
   localparam int NW   = TOTW + 1;
   localparam int TW   = COUNT_BITS + 1;
   localparam int PW   = NW + COUNT_BITS;
   localparam int QW   = 2 * PW;
   localparam int NUMW = QW + FRACTION_BITS;
   localparam int DENW = TW + 2 * TOTW;
   localparam int MCW  = $clog2(PW + 1);
   localparam int DCW  = $clog2(NUMW + 1);

   // Column stores and table bookkeeping.
   logic [COUNT_BITS-1:0] mem0 [MAX_COLUMNS];
   logic [COUNT_BITS-1:0] mem1 [MAX_COLUMNS];
   logic [COUNT_BITS-1:0] rd0_ff, rd1_ff;
   logic [TOTW-1:0]       r0_ff, r1_ff;
   logic [LW-1:0]         cnt_ff;
   logic                  ovf_ff;
   logic [CW-1:0]         col_ff;
   logic                  room;

   assign room = cnt_ff < LW'(MAX_COLUMNS);

   always_ff @(posedge clock) begin
      if (cmd.accept_col && room) begin
         mem0[cnt_ff[CW-1:0]] <= unaffected_count;
         mem1[cnt_ff[CW-1:0]] <= affected_count;
      end
      rd0_ff <= mem0[col_ff];
      rd1_ff <= mem1[col_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff  <= '0;
         r1_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.out_write) begin
         r0_ff  <= '0;
         r1_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.accept_col) begin
         if (room) begin
            r0_ff  <= r0_ff + TOTW'(unaffected_count);
            r1_ff  <= r1_ff + TOTW'(affected_count);
            cnt_ff <= cnt_ff + LW'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.col_clear) col_ff <= '0;
      else if (cmd.col_inc) col_ff <= col_ff + CW'(1);
   end

   // Per-column values.
   logic [NW-1:0] n_ff;
   logic [TW-1:0] t;
   logic [PW-1:0] a_ff, b_ff, d_ff;

   assign t = TW'(rd0_ff) + TW'(rd1_ff);

   always_ff @(posedge clock) begin
      if (cmd.check) n_ff <= NW'(r0_ff) + NW'(r1_ff);
   end

   // Shift-and-add multiplier, one multiplier bit per cycle.
   logic [QW-1:0]  mcand_ff, prod_ff, mcand_sel;
   logic [PW-1:0]  mplier_ff, mplier_sel;
   logic [MCW-1:0] mcnt_ff;
   logic           mbusy_ff, mbusy_in;

   always_comb begin
      unique case (cmd.mul_sel)
         MSEL_N_O0: begin
            mcand_sel  = QW'(n_ff);
            mplier_sel = PW'(rd0_ff);
         end
         MSEL_T_R0: begin
            mcand_sel  = QW'(t);
            mplier_sel = PW'(r0_ff);
         end
         MSEL_D_D: begin
            mcand_sel  = QW'(d_ff);
            mplier_sel = d_ff;
         end
         MSEL_B_R1: begin
            mcand_sel  = QW'(b_ff);
            mplier_sel = PW'(r1_ff);
         end
         default: begin
            mcand_sel  = '0;
            mplier_sel = '0;
         end
      endcase
   end

   always_comb begin
      mbusy_in = mbusy_ff;
      if (cmd.mul_start) mbusy_in = 1'b1;
      else if (mbusy_ff && mcnt_ff == MCW'(1)) mbusy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) mbusy_ff <= 1'b0;
      else mbusy_ff <= mbusy_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mcand_ff  <= mcand_sel;
         mplier_ff <= mplier_sel;
         prod_ff   <= '0;
         mcnt_ff   <= MCW'(PW);
      end else if (mbusy_ff) begin
         if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         mcnt_ff   <= mcnt_ff - MCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) a_ff <= prod_ff[PW-1:0];
      if (cmd.cap_b) begin
         b_ff <= prod_ff[PW-1:0];
         d_ff <= (a_ff >= prod_ff[PW-1:0]) ? a_ff - prod_ff[PW-1:0]
                                           : prod_ff[PW-1:0] - a_ff;
      end
   end

   // Restoring divider, one quotient bit per cycle; the quotient saturates.
   logic [NUMW-1:0]       dnum_ff;
   logic [DENW-1:0]       drem_ff, dden_ff;
   logic [VALUE_BITS-1:0] q_ff, term;
   logic                  sticky_ff;
   logic [DCW-1:0]        dcnt_ff;
   logic                  dbusy_ff, dbusy_in;
   logic [DENW:0]         trial, diff;
   logic                  ge;

   assign trial = {drem_ff, dnum_ff[NUMW-1]};
   assign ge    = trial >= {1'b0, dden_ff};
   assign diff  = trial - {1'b0, dden_ff};
   assign term  = sticky_ff ? VALUE_MAX : q_ff;

   always_comb begin
      dbusy_in = dbusy_ff;
      if (cmd.div_start) dbusy_in = 1'b1;
      else if (dbusy_ff && dcnt_ff == DCW'(1)) dbusy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) dbusy_ff <= 1'b0;
      else dbusy_ff <= dbusy_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.num_load) dnum_ff <= NUMW'(prod_ff) << FRACTION_BITS;
      else if (dbusy_ff) dnum_ff <= dnum_ff << 1;
      if (cmd.div_start) begin
         dden_ff   <= prod_ff[DENW-1:0];
         drem_ff   <= '0;
         q_ff      <= '0;
         sticky_ff <= 1'b0;
         dcnt_ff   <= DCW'(NUMW);
      end else if (dbusy_ff) begin
         drem_ff   <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
         q_ff      <= {q_ff[VALUE_BITS-2:0], ge};
         sticky_ff <= sticky_ff | q_ff[VALUE_BITS-1];
         dcnt_ff   <= dcnt_ff - DCW'(1);
      end
   end

   // Saturating sum of the column terms.
   logic [VALUE_BITS-1:0] sum_ff;
   logic [VALUE_BITS:0]   sum_wide;
   logic                  zero_ff;

   assign sum_wide = {1'b0, sum_ff} + {1'b0, term};

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         sum_ff  <= '0;
         zero_ff <= (r0_ff != '0 || r1_ff != '0) && (r0_ff == '0 || r1_ff == '0);
      end else if (cmd.acc) begin
         sum_ff <= sum_wide[VALUE_BITS] ? VALUE_MAX : sum_wide[VALUE_BITS-1:0];
      end
   end

   // Result register.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_write) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_write) begin
         chi_square_value <= sum_ff;
         row_total_zero   <= zero_ff;
         column_overflow  <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   assign status.n_zero   = (r0_ff == '0) && (r1_ff == '0);
   assign status.row_zero = (r0_ff == '0) || (r1_ff == '0);
   assign status.t_zero   = (t == '0);
   assign status.mul_busy = mbusy_ff;
   assign status.div_busy = dbusy_ff;
   assign status.col_last = (LW'(col_ff) + LW'(1)) == cnt_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

endmodule

/* src/chi_square_two_row_statistic_core.sv */
// Top level of the Pearson chi-square core for a two-row contingency table.
//
// Columns stream in on the req_ channel at one item per cycle while the core
// is loading; the item with tlast closes the table. The core then walks the
// stored columns: a column whose total is zero is passed over; any other one
// goes through the shared multiplier, which retires one bit of its PW-bit
// multiplier per cycle, PW = 2*COUNT_BITS + clog2(MAX_COLUMNS) + 1, and the
// restoring divider, which retires one quotient bit per cycle, NUMW =
// 2*PW + FRACTION_BITS bits in all. The result item leaves through an
// output register, so loading of the next table may begin while it waits;
// the closing pass of that table stalls only until the register is free.
// The value is unsigned with FRACTION_BITS fraction bits, truncated and
// saturated at all ones.
`timescale 1ns / 1ps
module chi_square_two_row_statistic_core #(
   parameter int MAX_COLUMNS   = chisq_pkg::DEF_MAX_COLUMNS,
   parameter int COUNT_BITS    = chisq_pkg::DEF_COUNT_BITS,
   parameter int FRACTION_BITS = chisq_pkg::DEF_FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // unaffected_count, affected_count, zero fill
   input  logic [((2*COUNT_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tlast,   // last_column
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // chi_square_value
   output logic [chisq_pkg::VALUE_BITS-1:0]      rsp_tdata,
   // row_total_zero, column_overflow
   output logic [1:0]                            rsp_tuser
);
   import chisq_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       zero_flag, ovf_flag;

   chisq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   chisq_dp #(
      .MAX_COLUMNS   (MAX_COLUMNS),
      .COUNT_BITS    (COUNT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .unaffected_count (req_tdata[COUNT_BITS-1:0]),
      .affected_count   (req_tdata[2*COUNT_BITS-1:COUNT_BITS]),
      .rsp_tready       (rsp_tready),
      .status           (status),
      .rsp_tvalid       (rsp_tvalid),
      .chi_square_value (rsp_tdata),
      .row_total_zero   (zero_flag),
      .column_overflow  (ovf_flag)
   );

   assign rsp_tuser = {ovf_flag, zero_flag};

   a_rsp_cleared: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item valid right after reset");

   a_close_leaves_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("core still takes items after the closing column");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(status.mul_busy && status.div_busy))
      else $error("multiplier and divider busy at once");

   a_zero_row_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("zero row total with nonzero statistic");

endmodule
